// File: hdl/fac_pkg.sv
// ----------------------------------------------------------------------------
// fac_pkg
// Shared constants, register codes and stage control type for the frustum
// box cull test.
// ----------------------------------------------------------------------------
package fac_pkg;

  // Default geometry of the coefficient and coordinate formats
  localparam int DEF_COEF_WIDTH     = 16;
  localparam int DEF_COEF_FRAC_BITS = 12;
  localparam int DEF_COORD_WIDTH    = 32;

  // Fixed formats of the ports
  localparam int FIELD_W         = 32;
  localparam int COORD_FRAC_BITS = 8;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_ADDR_W      = 5;

  localparam int NUM_ROWS   = 4;
  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;

  // Register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_ROW_X = 2'd0,
    REG_ROW_Y = 2'd1,
    REG_ROW_Z = 2'd2,
    REG_ROW_W = 2'd3
  } reg_idx_e;

  // Load enables for the stages inside each plane unit
  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } stage_en_t;

  // Identity matrix row: 1.0 in the given coefficient slot
  function automatic logic [CFG_DATA_W-1:0] row_reset(input int slot, input int coef_w,
                                                      input int frac_bits);
    return CFG_DATA_W'(1) << (frac_bits + slot * coef_w);
  endfunction

endpackage

// File: hdl/fac_cfg_regs.sv
// ----------------------------------------------------------------------------
// fac_cfg_regs
// Matrix row registers behind the APB-style port, and plane extraction
// (w row plus or minus the x, y and z rows).
// ----------------------------------------------------------------------------
module fac_cfg_regs #(
  parameter int COEF_WIDTH     = fac_pkg::DEF_COEF_WIDTH,
  parameter int COEF_FRAC_BITS = fac_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fac_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [fac_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [fac_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  output logic [fac_pkg::NUM_PLANES-1:0][fac_pkg::NUM_AXES-1:0][COEF_WIDTH:0] normal_o,
  output logic [fac_pkg::NUM_PLANES-1:0][COEF_WIDTH:0]                         dist_o
);
  import fac_pkg::*;

  logic [CFG_DATA_W-1:0] row_q [NUM_ROWS];
  logic                  wr_en;
  reg_idx_e              idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[CFG_ADDR_W-1:CFG_ADDR_W-2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        row_q[r] <= row_reset(r, COEF_WIDTH, COEF_FRAC_BITS);
      end
    end else if (wr_en) begin
      case (idx)
        REG_ROW_X: row_q[REG_ROW_X] <= pwdata;
        REG_ROW_Y: row_q[REG_ROW_Y] <= pwdata;
        REG_ROW_Z: row_q[REG_ROW_Z] <= pwdata;
        REG_ROW_W: row_q[REG_ROW_W] <= pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROW_X: prdata = row_q[REG_ROW_X];
      REG_ROW_Y: prdata = row_q[REG_ROW_Y];
      REG_ROW_Z: prdata = row_q[REG_ROW_Z];
      REG_ROW_W: prdata = row_q[REG_ROW_W];
      default:   prdata = '0;
    endcase
  end

  // Even planes add the row to the w row, odd planes subtract it
  always_comb begin
    logic signed [COEF_WIDTH:0] w_c;
    logic signed [COEF_WIDTH:0] o_c;
    logic signed [COEF_WIDTH:0] n_c;
    normal_o = '0;
    dist_o   = '0;
    w_c      = '0;
    o_c      = '0;
    n_c      = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int a = 0; a <= NUM_AXES; a++) begin
        w_c = (COEF_WIDTH+1)'($signed(row_q[REG_ROW_W][a*COEF_WIDTH +: COEF_WIDTH]));
        o_c = (COEF_WIDTH+1)'($signed(row_q[p/2][a*COEF_WIDTH +: COEF_WIDTH]));
        n_c = (p % 2 == 1) ? (w_c - o_c) : (w_c + o_c);
        if (a < NUM_AXES) begin
          normal_o[p][a] = n_c;
        end else begin
          dist_o[p] = n_c;
        end
      end
    end
  end

endmodule

// File: hdl/fac_plane_dot.sv
// ----------------------------------------------------------------------------
// fac_plane_dot
// One plane test: pick the far corner, multiply per axis, then sum with
// the scaled distance and keep the sign.
// ----------------------------------------------------------------------------
module fac_plane_dot #(
  parameter int COEF_WIDTH  = fac_pkg::DEF_COEF_WIDTH,
  parameter int COORD_WIDTH = fac_pkg::DEF_COORD_WIDTH
) (
  input  logic                                                 clk_i,
  input  fac_pkg::stage_en_t                                   en_i,
  input  logic [fac_pkg::NUM_AXES-1:0][COEF_WIDTH:0]           normal_i,
  input  logic [COEF_WIDTH:0]                                  dist_i,
  input  logic [fac_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]        box_lo_i,
  input  logic [fac_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]        box_hi_i,
  output logic                                                 culled_o
);
  import fac_pkg::*;

  localparam int PW = COEF_WIDTH + 1 + COORD_WIDTH;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] prod_d [NUM_AXES];
  logic signed [PW-1:0] prod_q [NUM_AXES];
  logic signed [SW-1:0] sum;
  logic                 culled_q;

  // Max corner where the normal component is zero or positive
  always_comb begin
    logic signed [COEF_WIDTH:0]    nrm;
    logic signed [COORD_WIDTH-1:0] crn;
    nrm = '0;
    crn = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      nrm       = $signed(normal_i[a]);
      crn       = nrm[COEF_WIDTH] ? $signed(box_lo_i[a]) : $signed(box_hi_i[a]);
      prod_d[a] = nrm * crn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod_q[a] <= prod_d[a];
      end
    end
  end

  assign sum = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2])
             + (SW'($signed(dist_i)) <<< COORD_FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i.sum_en) begin
      culled_q <= sum[SW-1];
    end
  end

  assign culled_o = culled_q;

endmodule

// File: hdl/frustum_aabb_cull_test.sv
// ----------------------------------------------------------------------------
// frustum_aabb_cull_test
// Streaming view-frustum test of axis-aligned boxes against six planes
// extracted from a view-projection matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one box per transaction (min and max corners, signed
//   Q24.8), taken when in_valid_i is high and in_stall_o is low.
//   Output channel: one visible flag per box, handed over when out_valid_o
//   is high and out_stall_i is low. Results leave in input order.
//   Configuration: four 64-bit matrix rows at byte addresses 0, 8, 16, 24;
//   write them only while no box is in flight.
//   Pipeline: four register stages (input register, multiply stage, sum
//   stage, output register); out_valid_o rises once a box has reached the
//   output register.
//   Throughput: one box per cycle unless stalled; the 17 x 32 bit multipliers
//   of the multiply stage, one per plane and axis, set the stage depth.
//   Reset: flushes every stage valid bit and loads the identity matrix.
//   Stall: a stalled output holds its result; bubbles in front of it still
//   close up, and in_stall_o rises only once every stage is full.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_test #(
  parameter int COEF_WIDTH     = fac_pkg::DEF_COEF_WIDTH,
  parameter int COEF_FRAC_BITS = fac_pkg::DEF_COEF_FRAC_BITS,
  parameter int COORD_WIDTH    = fac_pkg::DEF_COORD_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // box input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [fac_pkg::FIELD_W-1:0] box_min_x_i,
  input  logic signed [fac_pkg::FIELD_W-1:0] box_min_y_i,
  input  logic signed [fac_pkg::FIELD_W-1:0] box_min_z_i,
  input  logic signed [fac_pkg::FIELD_W-1:0] box_max_x_i,
  input  logic signed [fac_pkg::FIELD_W-1:0] box_max_y_i,
  input  logic signed [fac_pkg::FIELD_W-1:0] box_max_z_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               visible_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fac_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [fac_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [fac_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import fac_pkg::*;

  logic [NUM_PLANES-1:0][NUM_AXES-1:0][COEF_WIDTH:0] normal;
  logic [NUM_PLANES-1:0][COEF_WIDTH:0]               plane_dist;
  logic [NUM_PLANES-1:0]                             culled;

  // Stage valid bits: input register, multiply, sum, output
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  stage_en_t plane_en;

  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] lo_q;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] hi_q;
  logic                                 visible_q;

  fac_cfg_regs #(
    .COEF_WIDTH     (COEF_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .normal_o (normal),
    .dist_o   (plane_dist)
  );

  // A stage advances when it is empty or its successor advances; the
  // output stage advances when empty or its transaction is taken.
  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o      = !en1;
  assign plane_en.mul_en = en2;
  assign plane_en.sum_en = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Capture the corners, sign-extended or trimmed to the coordinate width
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      lo_q[0] <= COORD_WIDTH'(box_min_x_i);
      lo_q[1] <= COORD_WIDTH'(box_min_y_i);
      lo_q[2] <= COORD_WIDTH'(box_min_z_i);
      hi_q[0] <= COORD_WIDTH'(box_max_x_i);
      hi_q[1] <= COORD_WIDTH'(box_max_y_i);
      hi_q[2] <= COORD_WIDTH'(box_max_z_i);
    end
  end

  // Six plane units work side by side on the same box
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    fac_plane_dot #(
      .COEF_WIDTH  (COEF_WIDTH),
      .COORD_WIDTH (COORD_WIDTH)
    ) u_dot (
      .clk_i    (clk_i),
      .en_i     (plane_en),
      .normal_i (normal[p]),
      .dist_i   (plane_dist[p]),
      .box_lo_i (lo_q),
      .box_hi_i (hi_q),
      .culled_o (culled[p])
    );
  end

  // Visible unless any plane puts the far corner strictly behind it
  always_ff @(posedge clk_i) begin
    if (en4) begin
      visible_q <= ~|culled;
    end
  end

  assign out_valid_o = v4_q;
  assign visible_o   = visible_q;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams axis-aligned boxes through the frustum cull test. An internal
// predictor forms the six clip planes from the matrix rows written over the
// configuration port and flags each box as visible or culled. A scoreboard
// class holds the expected flags in order and compares every result
// transaction against the oldest one.
// ----------------------------------------------------------------------------
module testbench;
  import fac_pkg::*;

  localparam int CW              = DEF_COEF_WIDTH;
  localparam int FB              = DEF_COEF_FRAC_BITS;
  localparam int ONE             = 1 << FB;
  localparam int SETTLE_CYCLES   = 8;     // pipeline is four stages deep
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 130;

  // One box: min corner and max corner, axis 0 = x
  typedef struct packed {
    logic [NUM_AXES-1:0][FIELD_W-1:0] lo;
    logic [NUM_AXES-1:0][FIELD_W-1:0] hi;
  } box_t;

  // --------------------------------------------------------------------------
  // Scoreboard: matrix copy, visibility predictor and ordered expected flags
  // --------------------------------------------------------------------------
  class cull_scoreboard;
    logic [CFG_DATA_W-1:0] rows [NUM_ROWS];
    logic                  visible_q [$];
    int                    errors;

    function new();
      for (int r = 0; r < NUM_ROWS; r++) begin
        rows[r] = CFG_DATA_W'(1) << (FB + r * CW);
      end
      errors = 0;
    endfunction

    function void set_row(int idx, logic [CFG_DATA_W-1:0] value);
      rows[idx] = value;
    endfunction

    // Visible unless some plane puts its farthest corner on the negative side
    function logic predict_visible(box_t b);
      longint               acc;
      longint               n;
      longint               corner;
      logic signed [CW-1:0] cw;
      logic signed [CW-1:0] co;
      logic                 vis;
      vis = 1'b1;
      for (int p = 0; p < NUM_PLANES; p++) begin
        acc = 0;
        for (int a = 0; a < NUM_ROWS; a++) begin
          cw = rows[REG_ROW_W][a*CW +: CW];
          co = rows[p/2][a*CW +: CW];
          n  = (p % 2 == 1) ? longint'(cw) - longint'(co) : longint'(cw) + longint'(co);
          if (a < NUM_AXES) begin
            corner = (n >= 0) ? longint'($signed(b.hi[a])) : longint'($signed(b.lo[a]));
            acc += n * corner;
          end else begin
            acc += n <<< COORD_FRAC_BITS;
          end
        end
        if (acc < 0) vis = 1'b0;
      end
      return vis;
    endfunction

    function void note_box(box_t b);
      visible_q.push_back(predict_visible(b));
    endfunction

    function void check_result(logic got);
      logic want;
      if (visible_q.size() == 0) begin
        $display("%0t: result visible=%0b with no box outstanding", $time, got);
        errors++;
      end else begin
        want = visible_q.pop_front();
        if (got !== want) begin
          $display("%0t: visible mismatch: expected %0b, actual %0b", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals
  // --------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  box_t                  box_drv;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  visible_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  cull_scoreboard        sb;
  int                    idle_pct;
  int                    stall_pct;
  int                    quiet_cycles = 0;

  frustum_aabb_cull_test uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .box_min_x_i (box_drv.lo[0]),
    .box_min_y_i (box_drv.lo[1]),
    .box_min_z_i (box_drv.lo[2]),
    .box_max_x_i (box_drv.hi[0]),
    .box_max_y_i (box_drv.hi[1]),
    .box_max_z_i (box_drv.hi[2]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .visible_o   (visible_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result channel at the rate of the current phase
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Check every result transaction; stall is sampled at its pre-edge value
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      sb.check_result(visible_o);
    end
  end

  // Watchdog: end the run once nothing has moved for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic box_t make_box(int x0, int y0, int z0, int x1, int y1, int z1);
    box_t b;
    b.lo[0] = x0;
    b.lo[1] = y0;
    b.lo[2] = z0;
    b.hi[0] = x1;
    b.hi[1] = y1;
    b.hi[2] = z1;
    return b;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pack_row(int cx, int cy, int cz, int cw);
    logic [CFG_DATA_W-1:0] r;
    r = '0;
    r[0*CW +: CW] = cx[CW-1:0];
    r[1*CW +: CW] = cy[CW-1:0];
    r[2*CW +: CW] = cz[CW-1:0];
    r[3*CW +: CW] = cw[CW-1:0];
    return r;
  endfunction

  // Coefficient within +/-1.0, so boxes near the origin straddle the planes
  function automatic int small_coef();
    return int'($urandom_range(2 * ONE)) - ONE;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] small_row();
    return pack_row(small_coef(), small_coef(), small_coef(), small_coef());
  endfunction

  function automatic logic [FIELD_W-1:0] extreme_coord();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4:       return 32'hffff_ff00;
      default: return 32'h0000_0100;
    endcase
  endfunction

  // Mostly well-formed boxes near the origin, the rest raw, inverted or extreme
  function automatic box_t random_box();
    box_t b;
    int   kind;
    int   center;
    int   half;
    kind = $urandom_range(99);
    for (int a = 0; a < NUM_AXES; a++) begin
      center = int'($urandom_range(4095)) - 2048;
      half   = $urandom_range(767);
      if (kind < 65) begin
        b.lo[a] = center - half;
        b.hi[a] = center + half;
      end else if (kind < 80) begin
        b.lo[a] = $urandom;
        b.hi[a] = $urandom;
      end else if (kind < 90) begin
        b.lo[a] = center + half + 1;
        b.hi[a] = center - half;
      end else begin
        b.lo[a] = extreme_coord();
        b.hi[a] = extreme_coord();
      end
    end
    return b;
  endfunction

  // Drive one box transaction and record it once the block takes it
  task automatic send_box(input box_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    box_drv    <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_box(b);
  endtask

  // Drop valid and hold until every expected flag has come back
  task automatic drain(input int settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.visible_q.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the row lands at the edge with pready high
  task automatic write_row(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_row(idx, value);
  endtask

  task automatic set_matrix(input logic [CFG_DATA_W-1:0] rx, input logic [CFG_DATA_W-1:0] ry,
                            input logic [CFG_DATA_W-1:0] rz, input logic [CFG_DATA_W-1:0] rw);
    write_row(REG_ROW_X, rx);
    write_row(REG_ROW_Y, ry);
    write_row(REG_ROW_Z, rz);
    write_row(REG_ROW_W, rw);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb         = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    box_drv    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_pct   = 0;
    stall_pct  = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed boxes against the identity matrix left by reset: the frustum
    // is the cube from -1.0 to 1.0 (raw -256 .. 256) on every axis.
    send_box(make_box(-128, -128, -128, 128, 128, 128));
    send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    // Inverted extreme box: corners used as given, so it is culled
    send_box(make_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(512, 0, 0, 1024, 10, 10));
    // Max corner on the left plane: plane value exactly zero keeps the box
    send_box(make_box(-1000, 0, 0, -256, 0, 0));
    send_box(make_box(-1000, 0, 0, -257, 0, 0));
    send_box(make_box(0, 0, 256, 0, 0, 300));
    // Inverted but small: still inside
    send_box(make_box(100, 100, 100, -100, -100, -100));
    send_box(make_box(-1, -1, -1, -1, -1, -1));
    send_box(make_box(32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 0, 0));
    send_box(make_box(0, 32'h8000_0000, 0, 0, 32'h8000_0000, 0));
    drain(SETTLE_CYCLES);

    // Zero matrix: every normal is zero and every distance is zero, no cull
    set_matrix('0, '0, '0, '0);
    send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_box(make_box(32'h7fff_ffff, 0, 32'h8000_0000, 32'h8000_0000, 0, 32'h7fff_ffff));
    drain(SETTLE_CYCLES);

    // Zero normals with a negative distance: every box is culled
    write_row(REG_ROW_W, pack_row(0, 0, 0, -ONE));
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(-5, -5, -5, 5, 5, 5));
    drain(SETTLE_CYCLES);

    // Random phases: new matrix and new idling pattern each time
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1:       set_matrix(pack_row(32767, 32767, 32767, 32767),
                            pack_row(32767, 32767, 32767, 32767),
                            pack_row(32767, 32767, 32767, 32767),
                            pack_row(32767, 32767, 32767, 32767));
        2:       set_matrix(pack_row(-32768, -32768, -32768, -32768),
                            pack_row(-32768, -32768, -32768, -32768),
                            pack_row(-32768, -32768, -32768, -32768),
                            pack_row(-32768, -32768, -32768, -32768));
        3, 6:    set_matrix({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom});
        5:       set_matrix(pack_row(ONE, 0, 0, 0), pack_row(0, ONE, 0, 0),
                            pack_row(0, 0, ONE, 0), pack_row(0, 0, 0, ONE));
        default: set_matrix(small_row(), small_row(), small_row(), small_row());
      endcase

      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 65; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 7;  stall_pct = 7;  end
      endcase

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Hold off mid-phase until the pipeline has fully emptied
        if (i == ITEMS_PER_PHASE / 2) drain(0);
        send_box(random_box());
      end
      drain(SETTLE_CYCLES);
    end

    stall_pct = 0;
    drain(SETTLE_CYCLES);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
